FILE: hdl/bnms_pkg.sv
// Shared types, constants and helpers for the box suppression block.
`timescale 1ns / 1ps
package bnms_pkg;

  localparam int unsigned COORD_W   = 16;
  localparam int unsigned SCORE_W   = 16;
  localparam int unsigned EXT_W     = 17;
  localparam int unsigned AREA_W    = 2 * EXT_W;
  localparam int unsigned UNI_W     = AREA_W + 1;
  localparam int unsigned THR_W     = 17;
  localparam int unsigned PROD_W    = UNI_W + THR_W;
  localparam logic [THR_W-1:0] THR_RESET = 17'd26214;
  localparam logic signed [COORD_W+1:0] PIXEL_ONE = 18'sd16;

  typedef struct packed {
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
    logic [SCORE_W-1:0]        score;
  } box_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_SCAN,
    S_AEXT,
    S_AMUL,
    S_PRD,
    S_PEXT,
    S_PMI,
    S_PMB,
    S_PUN,
    S_PMU,
    S_PCMP,
    S_OUT
  } state_e;

  // hi - lo + one pixel, clamped at zero
  function automatic logic [EXT_W-1:0] extent(logic signed [COORD_W-1:0] lo,
                                              logic signed [COORD_W-1:0] hi);
    logic signed [COORD_W+1:0] e;
    e = $signed({{2{hi[COORD_W-1]}}, hi}) - $signed({{2{lo[COORD_W-1]}}, lo}) + PIXEL_ONE;
    if (e > 0) begin
      return e[EXT_W-1:0];
    end
    return '0;
  endfunction

endpackage

FILE: hdl/box_non_maximum_suppression.sv
// Greedy IoU non-maximum suppression over a stored set of scored boxes.
// Usage:
//   Input channel (in_valid_i/in_ready_o): one box per item, one item per cycle
//   while loading. An item with last_box_i closes the set and starts suppression;
//   boxes past MAX_BOXES are dropped and set overflow_o on every kept box.
//   Config channel (cfg_valid_i/cfg_ready_o): IoU threshold, Q1.16, always ready;
//   write it only while the block is idle.
//   Output channel (out_valid_o/out_ready_i): kept boxes in descending score
//   order (ties to the earlier box), last_kept_o on the final one.
// Processing of a set:
//   Each kept box costs one score scan through the single read port of the box
//   store, an area step for it, then a pair pass that skips each dead box and
//   runs each live box through the intersection, area, union and threshold
//   steps that use the one shared multiplier, then waits until the item is taken.
//   The input is not ready while a set is being processed.
// Reset clears the set and loads the default threshold; the store needs no
// clearing. A stalled receiver holds the result and the block waits.
module box_non_maximum_suppression #(
  parameter int unsigned MAX_BOXES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [15:0]           box_x1_i,
  input  logic signed [15:0]           box_y1_i,
  input  logic signed [15:0]           box_x2_i,
  input  logic signed [15:0]           box_y2_i,
  input  logic [15:0]                  box_score_i,
  input  logic                         last_box_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bnms_pkg::THR_W-1:0]   cfg_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [15:0]           kept_x1_o,
  output logic signed [15:0]           kept_y1_o,
  output logic signed [15:0]           kept_x2_o,
  output logic signed [15:0]           kept_y2_o,
  output logic [15:0]                  kept_score_o,
  output logic                         overflow_o,
  output logic                         last_kept_o
);
  import bnms_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_BOXES);
  localparam int unsigned CNT_W = $clog2(MAX_BOXES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BOXES);

  state_e state_q, state_d;

  logic [CNT_W-1:0]     count_q, scan_idx_q, b_idx_q;
  logic                 ovf_q, found_q, rd_vld_q;
  logic [MAX_BOXES-1:0] dead_q, valid_mask, alive;
  logic [THR_W-1:0]     thr_q;
  logic [IDX_W-1:0]     rd_idx_q, best_idx_q;
  box_t                 a_q, wr_box, rdata;
  logic [EXT_W-1:0]     ex_q, ey_q, bx_q, by_q;
  logic [AREA_W-1:0]    area_a_q, area_b_q, inter_q;
  logic [UNI_W-1:0]     uni_q, sum;
  logic                 keep_q;
  logic [PROD_W-1:0]    prod_q, mul_p;
  logic [UNI_W-1:0]     mul_a;
  logic [EXT_W-1:0]     mul_b;
  logic                 in_acc, store_we, out_acc, scan_done;
  logic [IDX_W-1:0]     rd_addr;

  assign wr_box = '{x1: box_x1_i, y1: box_y1_i, x2: box_x2_i, y2: box_y2_i,
                    score: box_score_i};

  always_comb begin
    for (int i = 0; i < MAX_BOXES; i++) begin
      valid_mask[i] = (CNT_W'(i) < count_q);
    end
  end
  assign alive = valid_mask & ~dead_q;

  assign in_acc    = in_valid_i && in_ready_o;
  assign out_acc   = out_valid_o && out_ready_i;
  assign store_we  = in_acc && (count_q < CNT_MAX);
  assign scan_done = (scan_idx_q == count_q) && !rd_vld_q;
  assign rd_addr   = (state_q == S_SCAN) ? scan_idx_q[IDX_W-1:0] : b_idx_q[IDX_W-1:0];

  bnms_store #(.DEPTH(MAX_BOXES)) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (store_we),
    .wr_addr_i (count_q[IDX_W-1:0]),
    .wr_data_i (wr_box),
    .rd_addr_i (rd_addr),
    .rd_data_o (rdata)
  );

  // shared multiplier
  always_comb begin
    unique case (state_q)
      S_PMB: begin
        mul_a = UNI_W'(bx_q);
        mul_b = by_q;
      end
      S_PMU: begin
        mul_a = uni_q;
        mul_b = thr_q;
      end
      default: begin
        mul_a = UNI_W'(ex_q);
        mul_b = ey_q;
      end
    endcase
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign sum   = UNI_W'(area_a_q) + UNI_W'(area_b_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD: if (in_acc && last_box_i) state_d = S_SCAN;
      S_SCAN: if (scan_done) state_d = found_q ? S_AEXT : S_LOAD;
      S_AEXT: state_d = S_AMUL;
      S_AMUL: state_d = S_PRD;
      S_PRD: begin
        if (b_idx_q == count_q) begin
          state_d = S_OUT;
        end else if (alive[b_idx_q[IDX_W-1:0]]) begin
          state_d = S_PEXT;
        end
      end
      S_PEXT: state_d = S_PMI;
      S_PMI:  state_d = S_PMB;
      S_PMB:  state_d = S_PUN;
      S_PUN:  state_d = S_PMU;
      S_PMU:  state_d = S_PCMP;
      S_PCMP: state_d = S_PRD;
      S_OUT:  if (out_acc) state_d = last_kept_o ? S_LOAD : S_SCAN;
      default: state_d = S_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = (state_q == S_LOAD);
    out_valid_o = (state_q == S_OUT);
    cfg_ready_o = 1'b1;
  end

  assign kept_x1_o    = a_q.x1;
  assign kept_y1_o    = a_q.y1;
  assign kept_x2_o    = a_q.x2;
  assign kept_y2_o    = a_q.y2;
  assign kept_score_o = a_q.score;
  assign overflow_o   = ovf_q;
  assign last_kept_o  = ~|alive;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      count_q    <= '0;
      ovf_q      <= 1'b0;
      dead_q     <= '0;
      thr_q      <= THR_RESET;
      scan_idx_q <= '0;
      rd_vld_q   <= 1'b0;
      found_q    <= 1'b0;
      b_idx_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      unique case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (count_q < CNT_MAX) begin
              count_q <= count_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
            scan_idx_q <= '0;
            rd_vld_q   <= 1'b0;
            found_q    <= 1'b0;
          end
        end
        S_SCAN: begin
          rd_vld_q <= (scan_idx_q != count_q);
          if (scan_idx_q != count_q) begin
            scan_idx_q <= scan_idx_q + 1'b1;
          end
          if (rd_vld_q && alive[rd_idx_q] && (!found_q || rdata.score > a_q.score)) begin
            found_q <= 1'b1;
          end
          if (scan_done) begin
            if (found_q) begin
              dead_q[best_idx_q] <= 1'b1;
            end else begin
              count_q <= '0;
              ovf_q   <= 1'b0;
              dead_q  <= '0;
            end
          end
        end
        S_AEXT: b_idx_q <= '0;
        S_PRD: begin
          if (b_idx_q != count_q && !alive[b_idx_q[IDX_W-1:0]]) begin
            b_idx_q <= b_idx_q + 1'b1;
          end
        end
        S_PCMP: begin
          if (!keep_q && (PROD_W'({inter_q, 16'b0}) > prod_q)) begin
            dead_q[b_idx_q[IDX_W-1:0]] <= 1'b1;
          end
          b_idx_q <= b_idx_q + 1'b1;
        end
        S_OUT: begin
          if (out_acc) begin
            scan_idx_q <= '0;
            rd_vld_q   <= 1'b0;
            found_q    <= 1'b0;
            if (last_kept_o) begin
              count_q <= '0;
              ovf_q   <= 1'b0;
              dead_q  <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_idx_q[IDX_W-1:0];
    unique case (state_q)
      S_SCAN: begin
        if (rd_vld_q && alive[rd_idx_q] && (!found_q || rdata.score > a_q.score)) begin
          a_q        <= rdata;
          best_idx_q <= rd_idx_q;
        end
      end
      S_AEXT: begin
        ex_q <= extent(a_q.x1, a_q.x2);
        ey_q <= extent(a_q.y1, a_q.y2);
      end
      S_AMUL: area_a_q <= mul_p[AREA_W-1:0];
      S_PEXT: begin
        ex_q <= extent((a_q.x1 > rdata.x1) ? a_q.x1 : rdata.x1,
                       (a_q.x2 < rdata.x2) ? a_q.x2 : rdata.x2);
        ey_q <= extent((a_q.y1 > rdata.y1) ? a_q.y1 : rdata.y1,
                       (a_q.y2 < rdata.y2) ? a_q.y2 : rdata.y2);
        bx_q <= extent(rdata.x1, rdata.x2);
        by_q <= extent(rdata.y1, rdata.y2);
      end
      S_PMI: inter_q <= mul_p[AREA_W-1:0];
      S_PMB: area_b_q <= mul_p[AREA_W-1:0];
      S_PUN: begin
        keep_q <= (sum <= UNI_W'(inter_q));
        uni_q  <= sum - UNI_W'(inter_q);
      end
      S_PMU: prod_q <= mul_p;
      default: ;
    endcase
  end

endmodule

FILE: hdl/bnms_store.sv
// Box store: one write port, one registered read port.
`timescale 1ns / 1ps
module bnms_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [IDX_W-1:0]     wr_addr_i,
  input  bnms_pkg::box_t       wr_data_i,
  input  logic [IDX_W-1:0]     rd_addr_i,
  output bnms_pkg::box_t       rd_data_o
);
  import bnms_pkg::*;

  box_t mem [DEPTH];
  box_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule
